// ===== hw/rtl/sic_pkg.sv =====
// Shared types and widths for the segment intersection core.
// Holds the request and result structs and the divider cell record.
// Depends on nothing.
package sic_pkg;

    localparam int CW   = 16;
    localparam int DW   = CW + 1;
    localparam int PW   = 2 * CW;
    localparam int CRW  = 2 * CW + 1;
    localparam int DENW = 2 * CW + 3;
    localparam int NW   = 3 * CW + 3;
    localparam int QW   = CW + 1;
    localparam int SW   = QW + 1;
    localparam int RW   = DENW + QW;

    typedef struct packed {
        logic signed [CW-1:0] a_start_x;
        logic signed [CW-1:0] a_start_y;
        logic signed [CW-1:0] a_end_x;
        logic signed [CW-1:0] a_end_y;
        logic signed [CW-1:0] b_start_x;
        logic signed [CW-1:0] b_start_y;
        logic signed [CW-1:0] b_end_x;
        logic signed [CW-1:0] b_end_y;
    } seg_t;

    typedef struct packed {
        logic                 hit;
        logic signed [CW-1:0] cross_x;
        logic signed [CW-1:0] cross_y;
    } res_t;

    typedef struct packed {
        logic [RW-1:0] rx;
        logic [RW-1:0] ry;
        logic [RW-1:0] dsh;
        logic [QW-1:0] qx;
        logic [QW-1:0] qy;
        logic          negx;
        logic          negy;
        logic          ovx;
        logic          ovy;
        logic          dz;
        seg_t          seg;
    } div_t;

endpackage

// ===== hw/rtl/sic_div_cell.sv =====
// One cell of the quotient chain: one restoring step for both x and y.
// Depends on sic_pkg.
module sic_div_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    input  logic          valid,
    input  sic_pkg::div_t d,
    output logic          q_valid,
    output sic_pkg::div_t q
);
    import sic_pkg::*;

    logic valid_reg;
    div_t data_reg;
    div_t data_next;
    logic ge_x;
    logic ge_y;

    always_comb
    begin
        ge_x = d.rx >= d.dsh;
        ge_y = d.ry >= d.dsh;
        data_next = d;
        data_next.rx = ge_x ? d.rx - d.dsh : d.rx;
        data_next.ry = ge_y ? d.ry - d.dsh : d.ry;
        data_next.qx = {d.qx[QW-2:0], ge_x};
        data_next.qy = {d.qy[QW-2:0], ge_y};
        data_next.dsh = d.dsh >> 1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            data_reg <= data_next;
        end
    end

    assign q_valid = valid_reg;
    assign q = data_reg;

endmodule

// ===== hw/rtl/segment_intersection_core.sv =====
// Top level of the segment intersection core: product stages, quotient chain, extent test.
// Depends on sic_pkg and sic_div_cell.
//
// Takes one request per cycle while not stalled and returns one result per request
// after five product and magnitude stages, one divider cell per quotient bit and one output
// register. The whole pipe advances together; it holds while a result waits under stall.
module segment_intersection_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          seg_valid,
    output logic          seg_stall,
    input  sic_pkg::seg_t seg,
    output logic          res_valid,
    input  logic          res_stall,
    output sic_pkg::res_t res
);
    import sic_pkg::*;

    function automatic logic outside(logic signed [SW-1:0] v,
                                     logic signed [CW-1:0] p,
                                     logic signed [CW-1:0] r);
        logic signed [SW-1:0] ps;
        logic signed [SW-1:0] rs;
        logic signed [SW-1:0] lo;
        logic signed [SW-1:0] hi;
        ps = SW'(p);
        rs = SW'(r);
        lo = (ps < rs) ? ps : rs;
        hi = (ps < rs) ? rs : ps;
        return (p != r) && ((v < lo) || (v > hi));
    endfunction

    logic adv;

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    seg_t s1_seg_reg, s2_seg_reg, s3_seg_reg, s4_seg_reg, s5_seg_reg;

    logic signed [DW-1:0] s1_dxa_reg, s1_dya_reg, s1_dxb_reg, s1_dyb_reg;
    logic signed [PW-1:0] s1_p1_reg, s1_p2_reg, s1_p3_reg, s1_p4_reg;

    logic signed [DW-1:0]   s2_dxa_reg, s2_dya_reg, s2_dxb_reg, s2_dyb_reg;
    logic signed [DENW-1:0] s2_q1_reg, s2_q2_reg;
    logic signed [CRW-1:0]  s2_c1_reg, s2_c2_reg;

    logic signed [DENW-1:0] s3_den_reg;
    logic signed [NW-1:0]   s3_m1_reg, s3_m2_reg, s3_m3_reg, s3_m4_reg;

    logic signed [DENW-1:0] s4_den_reg;
    logic signed [NW-1:0]   s4_nx_reg, s4_ny_reg;

    logic [RW-1:0] s5_ax_reg, s5_ay_reg, s5_ad_reg;
    logic          s5_negx_reg, s5_negy_reg, s5_dz_reg;

    logic [RW-1:0] d_shift;
    logic          chain_valid [QW+1];
    div_t          chain_data [QW+1];

    div_t                 tail;
    logic signed [SW-1:0] xq;
    logic signed [SW-1:0] yq;
    logic                 hit;

    logic res_valid_reg;
    res_t res_reg;
    res_t res_next;

    assign adv = !res_valid_reg || !res_stall;
    assign seg_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= seg_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            res_valid_reg <= chain_valid[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_seg_reg <= seg;
            s1_dxa_reg <= DW'(seg.a_end_x) - DW'(seg.a_start_x);
            s1_dya_reg <= DW'(seg.a_end_y) - DW'(seg.a_start_y);
            s1_dxb_reg <= DW'(seg.b_end_x) - DW'(seg.b_start_x);
            s1_dyb_reg <= DW'(seg.b_end_y) - DW'(seg.b_start_y);
            s1_p1_reg  <= PW'(seg.a_start_x) * PW'(seg.a_end_y);
            s1_p2_reg  <= PW'(seg.a_start_y) * PW'(seg.a_end_x);
            s1_p3_reg  <= PW'(seg.b_start_x) * PW'(seg.b_end_y);
            s1_p4_reg  <= PW'(seg.b_start_y) * PW'(seg.b_end_x);

            s2_seg_reg <= s1_seg_reg;
            s2_dxa_reg <= s1_dxa_reg;
            s2_dya_reg <= s1_dya_reg;
            s2_dxb_reg <= s1_dxb_reg;
            s2_dyb_reg <= s1_dyb_reg;
            s2_q1_reg  <= DENW'(s1_dyb_reg) * DENW'(s1_dxa_reg);
            s2_q2_reg  <= DENW'(s1_dxb_reg) * DENW'(s1_dya_reg);
            s2_c1_reg  <= CRW'(s1_p1_reg) - CRW'(s1_p2_reg);
            s2_c2_reg  <= CRW'(s1_p3_reg) - CRW'(s1_p4_reg);

            s3_seg_reg <= s2_seg_reg;
            s3_den_reg <= s2_q1_reg - s2_q2_reg;
            s3_m1_reg  <= NW'(s2_dxa_reg) * NW'(s2_c2_reg);
            s3_m2_reg  <= NW'(s2_dxb_reg) * NW'(s2_c1_reg);
            s3_m3_reg  <= NW'(s2_dya_reg) * NW'(s2_c2_reg);
            s3_m4_reg  <= NW'(s2_dyb_reg) * NW'(s2_c1_reg);

            s4_seg_reg <= s3_seg_reg;
            s4_den_reg <= s3_den_reg;
            s4_nx_reg  <= s3_m1_reg - s3_m2_reg;
            s4_ny_reg  <= s3_m3_reg - s3_m4_reg;

            s5_seg_reg  <= s4_seg_reg;
            s5_ax_reg   <= RW'(s4_nx_reg[NW-1] ? -s4_nx_reg : s4_nx_reg);
            s5_ay_reg   <= RW'(s4_ny_reg[NW-1] ? -s4_ny_reg : s4_ny_reg);
            s5_ad_reg   <= RW'(s4_den_reg[DENW-1] ? -s4_den_reg : s4_den_reg);
            s5_negx_reg <= s4_nx_reg[NW-1] ^ s4_den_reg[DENW-1];
            s5_negy_reg <= s4_ny_reg[NW-1] ^ s4_den_reg[DENW-1];
            s5_dz_reg   <= s4_den_reg == '0;

            res_reg <= res_next;
        end
    end

    always_comb
    begin
        d_shift = s5_ad_reg << QW;
        chain_valid[0] = s5_valid_reg;
        chain_data[0].rx   = s5_ax_reg;
        chain_data[0].ry   = s5_ay_reg;
        chain_data[0].dsh  = s5_ad_reg << (QW - 1);
        chain_data[0].qx   = '0;
        chain_data[0].qy   = '0;
        chain_data[0].negx = s5_negx_reg;
        chain_data[0].negy = s5_negy_reg;
        chain_data[0].ovx  = s5_ax_reg >= d_shift;
        chain_data[0].ovy  = s5_ay_reg >= d_shift;
        chain_data[0].dz   = s5_dz_reg;
        chain_data[0].seg  = s5_seg_reg;
    end

    for (genvar i = 0; i < QW; i++)
    begin : g_cell
        sic_div_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .valid   (chain_valid[i]),
            .d       (chain_data[i]),
            .q_valid (chain_valid[i+1]),
            .q       (chain_data[i+1])
        );
    end

    always_comb
    begin
        tail = chain_data[QW];
        xq = tail.negx ? -SW'({1'b0, tail.qx}) : SW'({1'b0, tail.qx});
        yq = tail.negy ? -SW'({1'b0, tail.qy}) : SW'({1'b0, tail.qy});
        hit = !tail.dz && !tail.ovx && !tail.ovy
            && !outside(xq, tail.seg.a_start_x, tail.seg.a_end_x)
            && !outside(xq, tail.seg.b_start_x, tail.seg.b_end_x)
            && !outside(yq, tail.seg.a_start_y, tail.seg.a_end_y)
            && !outside(yq, tail.seg.b_start_y, tail.seg.b_end_y);
        res_next.hit = hit;
        res_next.cross_x = hit ? CW'(xq) : '0;
        res_next.cross_y = hit ? CW'(yq) : '0;
    end

    assign res_valid = res_valid_reg;
    assign res = res_reg;

endmodule

// ===== test/tb_top.sv =====
// Testbench for segment_intersection_core: directed table then random segment pairs.
// Predicts each result with an exact integer intersection model and checks in order.
// Depends on sic_pkg and the core RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import sic_pkg::*;

    localparam int LATENCY = 23;

    logic clk;
    logic rst_n;
    logic seg_valid;
    logic seg_stall;
    seg_t seg;
    logic res_valid;
    logic res_stall;
    res_t res;

    res_t expected_q[$];
    int   fail_count;
    int   mismatch_count;
    bit   sender_done;
    bit   quiet_phase;
    bit   hold_receiver;

    segment_intersection_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .seg_valid (seg_valid),
        .seg_stall (seg_stall),
        .seg       (seg),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic signed [127:0] div_trunc(logic signed [127:0] n,
                                                      logic signed [127:0] d);
        logic signed [127:0] q;
        q = n / d;
        return q;
    endfunction

    function automatic bit off_axis(logic signed [127:0] v, logic signed [15:0] p,
                                    logic signed [15:0] q);
        logic signed [127:0] lo;
        logic signed [127:0] hi;
        if (p == q)
            return 1'b0;
        lo = (p < q) ? p : q;
        hi = (p < q) ? q : p;
        return (v < lo) || (v > hi);
    endfunction

    function automatic res_t predict_crossing(seg_t s);
        logic signed [127:0] x1, y1, x2, y2, x3, y3, x4, y4;
        logic signed [127:0] den, c1, c2, nx, ny, xi, yi;
        res_t r;
        x1 = s.a_start_x; y1 = s.a_start_y; x2 = s.a_end_x; y2 = s.a_end_y;
        x3 = s.b_start_x; y3 = s.b_start_y; x4 = s.b_end_x; y4 = s.b_end_y;
        r = '0;
        den = (y4 - y3) * (x2 - x1) - (x4 - x3) * (y2 - y1);
        if (den == 0)
            return r;
        c1 = x1 * y2 - y1 * x2;
        c2 = x3 * y4 - y3 * x4;
        nx = (x3 - x4) * c1 - (x1 - x2) * c2;
        ny = (y3 - y4) * c1 - (y1 - y2) * c2;
        xi = div_trunc(nx, den);
        yi = div_trunc(ny, den);
        if (!(off_axis(xi, s.a_start_x, s.a_end_x) || off_axis(xi, s.b_start_x, s.b_end_x) ||
              off_axis(yi, s.a_start_y, s.a_end_y) || off_axis(yi, s.b_start_y, s.b_end_y)))
        begin
            r.hit = 1'b1;
            r.cross_x = xi[15:0];
            r.cross_y = yi[15:0];
        end
        return r;
    endfunction

    function automatic logic signed [15:0] pick_coord();
        case ($urandom_range(0, 5))
            0: return 16'($urandom);
            1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            default: return $signed(16'($urandom_range(0, 1023))) - 16'sd512;
        endcase
    endfunction

    function automatic seg_t random_pair();
        seg_t s;
        int   mode;
        logic signed [15:0] cx, cy;
        mode = $urandom_range(0, 9);
        s.a_start_x = pick_coord(); s.a_start_y = pick_coord();
        s.a_end_x   = pick_coord(); s.a_end_y   = pick_coord();
        s.b_start_x = pick_coord(); s.b_start_y = pick_coord();
        s.b_end_x   = pick_coord(); s.b_end_y   = pick_coord();
        if (mode < 5)
        begin
            // cross around a shared center so many pairs hit
            cx = $signed(16'($urandom_range(0, 4095))) - 16'sd2048;
            cy = $signed(16'($urandom_range(0, 4095))) - 16'sd2048;
            s.a_start_x = cx - 16'($urandom_range(0, 2000));
            s.a_end_x   = cx + 16'($urandom_range(0, 2000));
            s.a_start_y = cy - 16'($urandom_range(0, 2000));
            s.a_end_y   = cy + 16'($urandom_range(0, 2000));
            s.b_start_x = cx + 16'($urandom_range(0, 2000));
            s.b_end_x   = cx - 16'($urandom_range(0, 2000));
            s.b_start_y = cy - 16'($urandom_range(0, 2000));
            s.b_end_y   = cy + 16'($urandom_range(0, 2000));
        end
        else if (mode == 5)
        begin
            s.b_start_x = s.a_start_x + 16'sd7;
            s.b_end_x   = s.a_end_x + 16'sd7;
            s.b_start_y = s.a_start_y;
            s.b_end_y   = s.a_end_y;
        end
        else if (mode == 6)
        begin
            s.a_end_x = s.a_start_x;
            s.b_end_y = s.b_start_y;
        end
        return s;
    endfunction

    task automatic send_request(seg_t s);
        seg_valid <= 1'b1;
        seg <= s;
        expected_q.push_back(predict_crossing(s));
        @(posedge clk);
        while (seg_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic sender_gap();
        if (!quiet_phase && $urandom_range(0, 3) == 0)
        begin
            seg_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
    endtask

    seg_t directed_tbl[$];
    res_t directed_exp[$];
    bit   directed_known[$];

    task automatic add_row(seg_t s, bit known, res_t r);
        directed_tbl.push_back(s);
        directed_known.push_back(known);
        directed_exp.push_back(r);
    endtask

    initial
    begin
        seg_t s;
        res_t none;
        res_t r;
        none = '0;
        rst_n = 1'b0;
        seg_valid = 1'b0;
        seg = '0;
        sender_done = 1'b0;
        quiet_phase = 1'b0;
        hold_receiver = 1'b0;

        add_row('0, 1'b1, none);
        s = '{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff,
              16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000};
        add_row(s, 1'b0, none);
        s = '{-16'sd160, 16'sd0, 16'sd160, 16'sd0, 16'sd0, -16'sd160, 16'sd0, 16'sd160};
        r = '{1'b1, 16'sd0, 16'sd0};
        add_row(s, 1'b1, r);
        s = '{16'sd0, 16'sd0, 16'sd16, 16'sd0, 16'sd0, 16'sd16, 16'sd16, 16'sd16};
        add_row(s, 1'b1, none);
        s = '{16'sd0, 16'sd0, 16'sd16, 16'sd16, 16'sd32, 16'sd32, 16'sd48, 16'sd48};
        add_row(s, 1'b1, none);
        s = '{16'sd0, 16'sd0, 16'sd16, 16'sd0, 16'sd100, -16'sd16, 16'sd100, 16'sd16};
        add_row(s, 1'b0, none);
        s = '{16'sd0, 16'sd0, 16'sd32, 16'sd0, 16'sd32, -16'sd16, 16'sd32, 16'sd16};
        add_row(s, 1'b0, none);
        s = '{16'sd0, 16'sd0, 16'sd3, 16'sd7, 16'sd0, 16'sd5, 16'sd9, 16'sd0};
        add_row(s, 1'b0, none);
        s = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh0, 16'sh0, 16'sh1, 16'sh1};
        add_row(s, 1'b1, none);
        s = '{16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000,
              16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff};
        add_row(s, 1'b0, none);
        s = '{16'sh5555, 16'shaaaa, 16'shaaaa, 16'sh5555,
              16'sh5555, 16'sh5555, 16'shaaaa, 16'shaaaa};
        add_row(s, 1'b0, none);
        s = '{-16'sd7, -16'sd3, 16'sd5, 16'sd11, 16'sd6, -16'sd9, -16'sd4, 16'sd8};
        add_row(s, 1'b0, none);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int i = 0; i < directed_tbl.size(); i++)
        begin
            if (directed_known[i] && predict_crossing(directed_tbl[i]) != directed_exp[i])
            begin
                fail_count++;
                $display("directed row %0d: table disagrees with prediction", i);
            end
            send_request(directed_tbl[i]);
            sender_gap();
        end

        hold_receiver = 1'b1;
        for (int i = 0; i < 60; i++)
            send_request(random_pair());
        seg_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(negedge clk);

        for (int i = 0; i < 380; i++)
        begin
            if (i == 300)
                quiet_phase = 1'b1;
            send_request(random_pair());
            sender_gap();
        end
        seg_valid <= 1'b0;
        sender_done = 1'b1;
    end

    initial
    begin
        res_stall = 1'b1;
        @(posedge rst_n);
        @(negedge clk);
        res_stall <= 1'b0;
        forever
        begin
            if (hold_receiver)
            begin
                hold_receiver = 1'b0;
                res_stall <= 1'b1;
                repeat (200) @(negedge clk);
                res_stall <= 1'b0;
            end
            if (!quiet_phase && $urandom_range(0, 4) == 0)
            begin
                res_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(negedge clk);
            end
            else
            begin
                res_stall <= 1'b0;
                @(negedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (expected_q.size() == 0)
            begin
                fail_count++;
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result hit=%0b x=%0d y=%0d",
                             res.hit, res.cross_x, res.cross_y);
            end
            else
            begin
                want = expected_q.pop_front();
                if (res.hit !== want.hit || res.cross_x !== want.cross_x ||
                    res.cross_y !== want.cross_y)
                begin
                    fail_count++;
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"mismatch: expected hit=%0b x=%0d y=%0d,",
                                  " got hit=%0b x=%0d y=%0d"},
                                 want.hit, want.cross_x, want.cross_y,
                                 res.hit, res.cross_x, res.cross_y);
                end
            end
        end
    end

    initial
    begin
        fail_count = 0;
        mismatch_count = 0;
        wait (sender_done);
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/sic_pkg.sv
hw/rtl/sic_div_cell.sv
hw/rtl/segment_intersection_core.sv
test/tb_top.sv
